FILE: rtl/core/icz_pkg.sv
// shared types and constants of the zero-border image convolution unit
package icz_pkg;

  localparam int MaxWidth = 1024;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = 12;
  localparam int LineRows = 4;
  localparam int BankW    = $clog2(LineRows);
  localparam int Win      = 5;
  localparam int PixW     = 8;
  localparam int CoefW    = 16;
  localparam int NumTaps  = 9;
  localparam int ProdW    = CoefW + PixW + 1;
  localparam int SumW     = 28;
  localparam int WidthW   = 11;
  localparam int HeightW  = 13;
  localparam int CfgIdxW  = 4;
  localparam int CfgDataW = 48;
  localparam int FracW    = 12;

  typedef enum logic [CfgIdxW-1:0] {
    CfgKernelMode = 4'd0,
    CfgLineRadius = 4'd1,
    CfgImageWidth = 4'd2,
    CfgImageHeight = 4'd3,
    CfgClampMode  = 4'd4,
    CfgCoefsLow   = 4'd5,
    CfgCoefsMid   = 4'd6,
    CfgCoefsHigh  = 4'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KmRow    = 2'd0,
    KmCol    = 2'd1,
    KmSquare = 2'd2
  } kmode_e;

  typedef struct packed {
    logic [PixW-1:0] pixel;
    logic            frame_start;
  } in_item_t;

  typedef struct packed {
    logic signed [SumW-1:0] filtered;
    logic [RowW-1:0]        out_row;
    logic [ColW-1:0]        out_col;
    logic                   frame_last;
  } out_item_t;

  typedef struct packed {
    kmode_e                           mode;
    logic [1:0]                       rad;
    logic [WidthW-1:0]                width;
    logic [HeightW-1:0]               height;
    logic                             clamp;
    logic [NumTaps-1:0][CoefW-1:0]    coef;
  } cfg_t;

  typedef struct packed {
    logic [PixW-1:0] px;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } pos_t;

  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            last;
    logic            interior;
  } meta_t;

  typedef logic [Win-1:0][Win-1:0][PixW-1:0] window_t;

endpackage

FILE: rtl/core/icz_cfg_regs.sv
// configuration registers and their effective values
module icz_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [icz_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [icz_pkg::CfgDataW-1:0] cfg_data_i,
  output icz_pkg::cfg_t                cfg_o
);
  import icz_pkg::*;

  logic [1:0]          mode_q, rad_q;
  logic [WidthW-1:0]   width_q;
  logic [HeightW-1:0]  height_q;
  logic                clamp_q;
  logic [CfgDataW-1:0] lo_q, mid_q, hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 2'd2;
      rad_q    <= 2'd1;
      width_q  <= WidthW'(640);
      height_q <= HeightW'(480);
      clamp_q  <= 1'b0;
      lo_q     <= '0;
      mid_q    <= '0;
      hi_q     <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgKernelMode:  mode_q   <= cfg_data_i[1:0];
        CfgLineRadius:  rad_q    <= cfg_data_i[1:0];
        CfgImageWidth:  width_q  <= cfg_data_i[WidthW-1:0];
        CfgImageHeight: height_q <= cfg_data_i[HeightW-1:0];
        CfgClampMode:   clamp_q  <= cfg_data_i[0];
        CfgCoefsLow:    lo_q     <= cfg_data_i;
        CfgCoefsMid:    mid_q    <= cfg_data_i;
        CfgCoefsHigh:   hi_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o = '0;
    if (mode_q == 2'd0) begin
      cfg_o.mode = KmRow;
    end else if (mode_q == 2'd1) begin
      cfg_o.mode = KmCol;
    end else begin
      cfg_o.mode = KmSquare;
    end
    if (cfg_o.mode == KmSquare) begin
      cfg_o.rad = 2'd1;
    end else if (rad_q > 2'd2) begin
      cfg_o.rad = 2'd2;
    end else begin
      cfg_o.rad = rad_q;
    end
    if (width_q == '0) begin
      cfg_o.width = WidthW'(1);
    end else if (width_q > WidthW'(MaxWidth)) begin
      cfg_o.width = WidthW'(MaxWidth);
    end else begin
      cfg_o.width = width_q;
    end
    if (height_q == '0) begin
      cfg_o.height = HeightW'(1);
    end else if (height_q > HeightW'(4096)) begin
      cfg_o.height = HeightW'(4096);
    end else begin
      cfg_o.height = height_q;
    end
    cfg_o.clamp = clamp_q;
    cfg_o.coef  = {hi_q, mid_q, lo_q};
  end

endmodule

FILE: rtl/core/icz_line_buf.sv
// line store: one bank per buffered row, all banks read at one column
module icz_line_buf (
  input  logic                                         clk_i,
  input  logic                                         en_i,
  input  logic [icz_pkg::ColW-1:0]                     addr_i,
  input  logic [icz_pkg::BankW-1:0]                    wr_bank_i,
  input  logic [icz_pkg::PixW-1:0]                     wr_data_i,
  output logic [icz_pkg::LineRows-1:0][icz_pkg::PixW-1:0] rd_data_o
);
  import icz_pkg::*;

  for (genvar b = 0; b < LineRows; b++) begin : g_bank
    logic [PixW-1:0] mem [MaxWidth];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rd_data_o[b] <= mem[addr_i];
        if (wr_bank_i == BankW'(b)) begin
          mem[addr_i] <= wr_data_i;
        end
      end
    end
  end

endmodule

FILE: rtl/core/icz_window.sv
// pixel window and output position stage
module icz_window (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  icz_pkg::cfg_t                                   cfg_i,
  input  logic                                            s1_valid_i,
  input  icz_pkg::pos_t                                   s1_pos_i,
  input  logic [icz_pkg::LineRows-1:0][icz_pkg::PixW-1:0] line_i,
  output logic                                            s1_go_o,
  output logic                                            s2_valid_o,
  output icz_pkg::meta_t                                  s2_meta_o,
  output icz_pkg::window_t                                win_o,
  input  logic                                            s2_take_i
);
  import icz_pkg::*;

  window_t win_q, win_d;
  logic    s2_v_q;
  meta_t   meta_q, meta_d;
  logic    emit;

  logic [HeightW-1:0] r13, h13, rad13, orow13;
  logic [11:0]        c12, w12, rad12, ocol12;
  logic [BankW-1:0]   slot;

  assign s1_go_o = !s2_v_q || s2_take_i;

  always_comb begin
    win_d = win_q;
    for (int i = 0; i < Win; i++) begin
      for (int j = 0; j < Win - 1; j++) begin
        win_d[i][j] = win_q[i][j+1];
      end
    end
    for (int k = 1; k < Win; k++) begin
      slot = s1_pos_i.row[BankW-1:0] - BankW'(k);
      win_d[Win-1-k][Win-1] = line_i[slot];
    end
    win_d[Win-1][Win-1] = s1_pos_i.px;
  end

  always_comb begin
    r13    = {1'b0, s1_pos_i.row};
    h13    = cfg_i.height;
    rad13  = {11'b0, cfg_i.rad};
    c12    = {2'b0, s1_pos_i.col};
    w12    = {1'b0, cfg_i.width};
    rad12  = {10'b0, cfg_i.rad};
    emit   = 1'b0;
    orow13 = r13;
    ocol12 = c12;
    meta_d = '0;
    case (cfg_i.mode)
      KmRow: begin
        if (c12 >= rad12) begin
          emit   = 1'b1;
          ocol12 = c12 - rad12;
        end else if (c12 + w12 >= rad12) begin
          emit   = r13 != '0;
          orow13 = r13 - HeightW'(1);
          ocol12 = c12 + w12 - rad12;
        end else begin
          emit   = r13 >= HeightW'(2);
          orow13 = r13 - HeightW'(2);
          ocol12 = c12 + w12 + w12 - rad12;
        end
        meta_d.interior = ocol12 >= rad12 && ocol12 + rad12 <= w12 - 12'd1;
      end
      KmCol: begin
        emit   = r13 >= rad13;
        orow13 = r13 - rad13;
        meta_d.interior = orow13 >= rad13 && orow13 + rad13 <= h13 - HeightW'(1);
      end
      default: begin
        if (c12 != '0) begin
          emit   = r13 != '0;
          orow13 = r13 - HeightW'(1);
          ocol12 = c12 - 12'd1;
        end else begin
          emit   = r13 >= HeightW'(2);
          orow13 = r13 - HeightW'(2);
          ocol12 = w12 - 12'd1;
        end
        meta_d.interior = orow13 >= HeightW'(1) && orow13 + HeightW'(1) <= h13 - HeightW'(1)
                       && ocol12 >= 12'd1 && ocol12 + 12'd1 <= w12 - 12'd1;
      end
    endcase
    meta_d.row  = orow13[RowW-1:0];
    meta_d.col  = ocol12[ColW-1:0];
    meta_d.last = (r13 == h13 - HeightW'(1)) && (c12 == w12 - 12'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      s2_v_q <= 1'b0;
    end else if (s1_valid_i && s1_go_o) begin
      win_q  <= win_d;
      s2_v_q <= emit;
    end else if (s2_take_i) begin
      s2_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i && s1_go_o) begin
      meta_q <= meta_d;
    end
  end

  assign s2_valid_o = s2_v_q;
  assign s2_meta_o  = meta_q;
  assign win_o      = win_q;

endmodule

FILE: rtl/core/icz_mac.sv
// tap products, sum, clamp and result register
module icz_mac (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  icz_pkg::cfg_t      cfg_i,
  input  logic               s2_valid_i,
  input  icz_pkg::meta_t     s2_meta_i,
  input  icz_pkg::window_t   win_i,
  output logic               s2_take_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output icz_pkg::out_item_t out_item_o
);
  import icz_pkg::*;

  logic [PixW-1:0]         pix [NumTaps];
  logic signed [ProdW-1:0] prod_d [NumTaps];
  logic signed [ProdW-1:0] prod_q [NumTaps];
  meta_t                   meta_q;
  logic                    s3_v_q, out_v_q;
  logic                    out_go, s3_go;
  logic [2:0]              off;
  logic signed [SumW-1:0]  sum, res;
  out_item_t               out_q;

  assign out_go    = !out_v_q || out_ready_i;
  assign s3_go     = !s3_v_q || out_go;
  assign s2_take_o = s2_valid_i && s3_go;

  always_comb begin
    off = 3'd4 - {cfg_i.rad, 1'b0};
    for (int i = 0; i < NumTaps; i++) begin
      pix[i] = '0;
    end
    case (cfg_i.mode)
      KmRow: begin
        for (int i = 0; i < Win; i++) begin
          if (3'(i) <= {cfg_i.rad, 1'b0}) begin
            pix[i] = win_i[Win-1][off + 3'(i)];
          end
        end
      end
      KmCol: begin
        for (int i = 0; i < Win; i++) begin
          if (3'(i) <= {cfg_i.rad, 1'b0}) begin
            pix[i] = win_i[off + 3'(i)][Win-1];
          end
        end
      end
      default: begin
        for (int a = 0; a < 3; a++) begin
          for (int b = 0; b < 3; b++) begin
            pix[3*a+b] = win_i[2+a][2+b];
          end
        end
      end
    endcase
    for (int i = 0; i < NumTaps; i++) begin
      prod_d[i] = $signed(cfg_i.coef[i]) * $signed({1'b0, pix[i]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_take_o) begin
      prod_q <= prod_d;
      meta_q <= s2_meta_i;
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NumTaps; i++) begin
      sum = sum + SumW'(prod_q[i]);
    end
    if (!meta_q.interior) begin
      res = '0;
    end else if (!cfg_i.clamp) begin
      res = sum;
    end else if (sum[SumW-1]) begin
      res = '0;
    end else if (|sum[SumW-1:FracW+PixW]) begin
      res = SumW'(255);
    end else begin
      res = SumW'(sum[FracW+PixW-1:FracW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s3_go) begin
        s3_v_q <= s2_valid_i;
      end
      if (out_go) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_go && s3_v_q) begin
      out_q.filtered   <= res;
      out_q.out_row    <= meta_q.row;
      out_q.out_col    <= meta_q.col;
      out_q.frame_last <= meta_q.last;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

FILE: rtl/core/image_convolution_zero_border_unit.sv
// top level of the zero-border image convolution unit
//
//   port group  dir  payload
//   in_*        in   in_item_t  {pixel, frame_start}
//   out_*       out  out_item_t {filtered, out_row, out_col, frame_last}
//   cfg_*       in   cfg_index_i, cfg_data_i
//
// one pixel item per clock while the result output does not stall the pipeline
// stages: position and line store read, window, tap products, sum and clamp
// reset clears counters, window and stage valids; line store is not cleared
// a stalled result keeps accepting items until the four stage registers fill
module image_convolution_zero_border_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  icz_pkg::in_item_t            in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output icz_pkg::out_item_t           out_item_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [icz_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [icz_pkg::CfgDataW-1:0] cfg_data_i
);
  import icz_pkg::*;

  cfg_t  cfg;
  logic  accept, s1_v_q, s1_go, s2_v, s2_take;
  pos_t  s1_q;
  meta_t s2_meta;
  window_t win;
  logic [LineRows-1:0][PixW-1:0] line_rd;

  logic [RowW-1:0]    row_q, row_d, r0, r_cur;
  logic [ColW-1:0]    col_q, col_d, c0, c_cur;
  logic [HeightW-1:0] r_inc, r_p1;
  logic [WidthW-1:0]  c_p1;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !s1_v_q || s1_go;
  assign accept      = in_valid_i && in_ready_o;

  icz_cfg_regs u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_index_i, .cfg_data_i, .cfg_o(cfg)
  );

  always_comb begin
    c0 = in_item_i.frame_start ? '0 : col_q;
    r0 = in_item_i.frame_start ? '0 : row_q;
    if ({1'b0, c0} >= cfg.width) begin
      c_cur = '0;
      r_inc = {1'b0, r0} + HeightW'(1);
    end else begin
      c_cur = c0;
      r_inc = {1'b0, r0};
    end
    r_cur = (r_inc >= cfg.height) ? '0 : r_inc[RowW-1:0];
    c_p1  = {1'b0, c_cur} + WidthW'(1);
    r_p1  = {1'b0, r_cur} + HeightW'(1);
    if (c_p1 >= cfg.width) begin
      col_d = '0;
      row_d = (r_p1 >= cfg.height) ? '0 : r_p1[RowW-1:0];
    end else begin
      col_d = c_p1[ColW-1:0];
      row_d = r_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      s1_v_q <= 1'b0;
    end else begin
      if (accept) begin
        row_q <= row_d;
        col_q <= col_d;
      end
      if (in_ready_o) begin
        s1_v_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q.px  <= in_item_i.pixel;
      s1_q.row <= r_cur;
      s1_q.col <= c_cur;
    end
  end

  icz_line_buf u_lbuf (
    .clk_i,
    .en_i      (accept),
    .addr_i    (c_cur),
    .wr_bank_i (r_cur[BankW-1:0]),
    .wr_data_i (in_item_i.pixel),
    .rd_data_o (line_rd)
  );

  icz_window u_win (
    .clk_i, .rst_ni,
    .cfg_i      (cfg),
    .s1_valid_i (s1_v_q),
    .s1_pos_i   (s1_q),
    .line_i     (line_rd),
    .s1_go_o    (s1_go),
    .s2_valid_o (s2_v),
    .s2_meta_o  (s2_meta),
    .win_o      (win),
    .s2_take_i  (s2_take)
  );

  icz_mac u_mac (
    .clk_i, .rst_ni,
    .cfg_i       (cfg),
    .s2_valid_i  (s2_v),
    .s2_meta_i   (s2_meta),
    .win_i       (win),
    .s2_take_o   (s2_take),
    .out_valid_o,
    .out_ready_i,
    .out_item_o
  );

  a_clamp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cfg.clamp |->
      !out_item_o.filtered[SumW-1] && out_item_o.filtered[SumW-1:PixW] == '0)
    else $error("clamped result out of range");

  a_stall_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_v_q)
    else $error("input stalled with empty first stage");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_v_q)
    else $error("accepted item lost before first stage");

endmodule
